/* src/ukm_pkg.sv */
`default_nettype none
package ukm_pkg;

  // Fixed sizes of the key space and the matrix
  localparam int KEY_CODES   = 256;
  localparam int MATRIX_KEYS = 64;
  localparam int POS_W       = 6;

  // Request types
  localparam logic [1:0] REQ_KEY   = 2'd0;
  localparam logic [1:0] REQ_MAP   = 2'd1;
  localparam logic [1:0] REQ_FLUSH = 2'd2;

  // Map columns
  localparam logic [1:0] COL_NORMAL = 2'd0;
  localparam logic [1:0] COL_SHIFT  = 2'd1;
  localparam logic [1:0] COL_ALTGR  = 2'd2;
  localparam logic [1:0] COL_NONE   = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_LANGUAGE   = 2'd0;
  localparam logic [1:0] CFG_SHIFT_POS  = 2'd1;
  localparam logic [1:0] CFG_CHORD_MASK = 2'd2;

  // Result kinds
  localparam logic KIND_CODE  = 1'b0;
  localparam logic KIND_RESET = 1'b1;

  // Key and modifier constants
  localparam logic [7:0] DELETE_KEY = 8'h4C;
  localparam logic [7:0] MOD_SHIFTS = 8'h22;
  localparam int         MOD_ALTGR_BIT = 6;
  localparam int         UNMAPPED_BIT  = 7;
  localparam int         NEED_BIT      = 6;

  // Reset values of the configuration registers
  localparam logic [POS_W-1:0] SHIFT_POS_RESET  = 6'd56;
  localparam logic [7:0]       CHORD_MASK_RESET = 8'd5;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] key_code;
    logic [7:0] modifiers;
    logic       is_release;
    logic       map_language;
    logic [6:0] map_index;
    logic [1:0] map_column;
    logic [7:0] map_entry;
  } req_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] matrix_code;
    logic       last;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOOK,
    ST_PLAN,
    ST_CHORD,
    ST_SHIFT,
    ST_MAKE,
    ST_BREAK,
    ST_UNSHIFT,
    ST_FLUSH
  } state_t;

  // Which word the datapath loads into the output register
  typedef enum logic [2:0] {
    SEL_CHORD,
    SEL_SHIFT,
    SEL_MAKE,
    SEL_BREAK,
    SEL_UNSHIFT,
    SEL_FLUSH
  } sel_t;

  typedef struct packed {
    logic accept;
    logic look;
    logic emit;
    sel_t sel;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic flush;
    logic chord;
    logic mapped;
    logic shift_chg;
    logic rel_ok;
    logic unshift;
  } flags_t;

  typedef struct packed {
    flags_t flags;
    logic   out_free;
    logic   flush_done;
  } stat_t;

endpackage
`default_nettype wire

/* src/usb_key_to_matrix_translator.sv */
`default_nettype none
// A key word passes the lookup and decision states after accept before its first result
// word, then gives one word a cycle while the output is taken; a map write gives no word.
// A new request is accepted only in the idle state, once the previous one is done;
// release-all gives 64 words.
// Reset clears held-key valid bits, shift state, need count and config registers;
// the layout map is not cleared and holds nothing defined until written.
module usb_key_to_matrix_translator #(
  parameter int NUM_LAYOUTS = 2,
  parameter int MAP_ROWS    = 128
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire ukm_pkg::req_t req,
  output logic               res_valid,
  input  wire logic          res_ready,
  output ukm_pkg::res_t      res,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [7:0]    cfg_data
);
  import ukm_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Registers take a write in any cycle
  assign cfg_ready = 1'b1;

  ukm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_type  (req.req_type),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ukm_datapath #(
    .NUM_LAYOUTS (NUM_LAYOUTS),
    .MAP_ROWS    (MAP_ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule
`default_nettype wire

/* src/ukm_ctrl.sv */
`default_nettype none
module ukm_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  input  wire logic [1:0]     req_type,
  output logic                req_ready,
  input  wire ukm_pkg::stat_t stat,
  output ukm_pkg::cmd_t       cmd
);
  import ukm_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    cmd.accept = 1'b0;
    cmd.look   = 1'b0;
    cmd.emit   = 1'b0;
    cmd.sel    = SEL_MAKE;
    cmd.last   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready  = 1'b1;
        cmd.accept = req_valid;
        if (req_valid && (req_type == REQ_KEY || req_type == REQ_FLUSH)) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        cmd.look   = 1'b1;
        state_next = ST_PLAN;
      end
      ST_PLAN: begin
        if (stat.flags.flush) begin
          state_next = ST_FLUSH;
        end else if (stat.flags.chord) begin
          state_next = ST_CHORD;
        end else if (stat.flags.mapped) begin
          state_next = stat.flags.shift_chg ? ST_SHIFT : ST_MAKE;
        end else if (stat.flags.rel_ok) begin
          state_next = ST_BREAK;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_CHORD: begin
        cmd.sel  = SEL_CHORD;
        cmd.last = !stat.flags.mapped;
        cmd.emit = stat.out_free;
        if (stat.out_free) begin
          if (stat.flags.mapped) begin
            state_next = stat.flags.shift_chg ? ST_SHIFT : ST_MAKE;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_SHIFT: begin
        cmd.sel  = SEL_SHIFT;
        cmd.emit = stat.out_free;
        if (stat.out_free) begin
          state_next = ST_MAKE;
        end
      end
      ST_MAKE: begin
        cmd.sel  = SEL_MAKE;
        cmd.last = 1'b1;
        cmd.emit = stat.out_free;
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_BREAK: begin
        cmd.sel  = SEL_BREAK;
        cmd.last = !stat.flags.unshift;
        cmd.emit = stat.out_free;
        if (stat.out_free) begin
          state_next = stat.flags.unshift ? ST_UNSHIFT : ST_IDLE;
        end
      end
      ST_UNSHIFT: begin
        cmd.sel  = SEL_UNSHIFT;
        cmd.last = 1'b1;
        cmd.emit = stat.out_free;
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        cmd.sel  = SEL_FLUSH;
        cmd.last = stat.flush_done;
        cmd.emit = stat.out_free;
        if (stat.out_free && stat.flush_done) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Emit only into a free output slot
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.out_free)
    else $error("word emitted into a full output register");

  // A shift make is always followed by the key's make
  a_shift_then_make: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHIFT && cmd.emit) |=> state == ST_MAKE)
    else $error("shift word not followed by make");

  // Flush keeps going until its last word
  a_flush_runs: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH && cmd.emit && !cmd.last) |=> state == ST_FLUSH)
    else $error("flush stopped early");

endmodule
`default_nettype wire

/* src/ukm_datapath.sv */
`default_nettype none
module ukm_datapath #(
  parameter int NUM_LAYOUTS = 2,
  parameter int MAP_ROWS    = 128
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire ukm_pkg::req_t  req,
  input  wire ukm_pkg::cmd_t  cmd,
  output ukm_pkg::stat_t      stat,
  input  wire logic           cfg_valid,
  input  wire logic [1:0]     cfg_index,
  input  wire logic [7:0]     cfg_data,
  output logic                res_valid,
  input  wire logic           res_ready,
  output ukm_pkg::res_t       res
);
  import ukm_pkg::*;

  localparam int LANG_W    = (NUM_LAYOUTS > 1) ? $clog2(NUM_LAYOUTS) : 1;
  localparam int ROW_W     = $clog2(MAP_ROWS);
  localparam int ADDR_W    = LANG_W + ROW_W + 2;
  localparam int MAP_DEPTH = 1 << ADDR_W;

  // Configuration
  logic             language;
  logic [POS_W-1:0] shift_position;
  logic [7:0]       reset_chord_mask;

  // Layout map and held-key table
  logic [7:0]           map_mem [MAP_DEPTH];
  logic [7:0]           map_q;
  logic [POS_W:0]       held_mem [KEY_CODES];
  logic [POS_W:0]       held_q;
  logic [KEY_CODES-1:0] held_bits;

  // Current item
  logic [7:0] kc;
  logic [7:0] mods;
  logic       rel;
  logic       flush_req;

  logic             shift_held;
  logic [8:0]       need_count;
  logic [POS_W-1:0] flush_cnt;
  flags_t           flags;

  logic [1:0]        col;
  logic [ADDR_W-1:0] map_rd_addr;
  logic [ADDR_W-1:0] map_wr_addr;
  logic              map_wr;
  logic              out_free;
  logic              key_ok;
  logic              held_now;
  logic [8:0]        count_after;
  flags_t            flags_c;
  res_t              word;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      language         <= 1'b0;
      shift_position   <= SHIFT_POS_RESET;
      reset_chord_mask <= CHORD_MASK_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LANGUAGE:   language         <= cfg_data[0];
        CFG_SHIFT_POS:  shift_position   <= cfg_data[POS_W-1:0];
        CFG_CHORD_MASK: reset_chord_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  // Map column from the modifier byte
  always_comb begin
    if (req.modifiers[MOD_ALTGR_BIT]) begin
      col = COL_ALTGR;
    end else if ((req.modifiers & MOD_SHIFTS) != 8'd0) begin
      col = COL_SHIFT;
    end else begin
      col = COL_NORMAL;
    end
  end

  assign map_rd_addr = {LANG_W'(language), ROW_W'(req.key_code), col};
  assign map_wr_addr = {LANG_W'(req.map_language), ROW_W'(req.map_index), req.map_column};
  assign map_wr = cmd.accept && req.req_type == REQ_MAP && req.map_column != COL_NONE &&
                  (32'(req.map_language) < NUM_LAYOUTS);

  // Layout map: write on a map word with a valid column and language, read on any accepted word
  always_ff @(posedge clk) begin
    if (map_wr) begin
      map_mem[map_wr_addr] <= req.map_entry;
    end
    if (cmd.accept) begin
      map_q <= map_mem[map_rd_addr];
    end
  end

  // Held-key record: written on make, read on accept
  always_ff @(posedge clk) begin
    if (cmd.emit && cmd.sel == SEL_MAKE) begin
      held_mem[kc] <= {map_q[NEED_BIT], map_q[POS_W-1:0]};
    end
    if (cmd.accept) begin
      held_q <= held_mem[req.key_code];
    end
  end

  // Latch the accepted word
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kc        <= req.key_code;
      mods      <= req.modifiers;
      rel       <= req.is_release;
      flush_req <= (req.req_type == REQ_FLUSH);
    end
  end

  // Decide what the word produces
  always_comb begin
    key_ok   = (32'(kc) < MAP_ROWS) && (32'(language) < NUM_LAYOUTS);
    held_now = held_bits[kc];
    if (held_q[POS_W] && need_count != 9'd0) begin
      count_after = need_count - 9'd1;
    end else begin
      count_after = need_count;
    end
    flags_c.flush     = flush_req;
    flags_c.chord     = !flush_req && !rel && kc == DELETE_KEY && mods == reset_chord_mask;
    flags_c.mapped    = !flush_req && !rel && !held_now && key_ok && !map_q[UNMAPPED_BIT];
    flags_c.shift_chg = flags_c.mapped && (map_q[NEED_BIT] != shift_held);
    flags_c.rel_ok    = !flush_req && rel && held_now;
    flags_c.unshift   = flags_c.rel_ok && shift_held && count_after == 9'd0;
  end

  always_ff @(posedge clk) begin
    if (cmd.look) begin
      flags <= flags_c;
    end
  end

  // Update held keys, shift state and need count as words go out
  always_ff @(posedge clk) begin
    if (rst) begin
      held_bits  <= '0;
      shift_held <= 1'b0;
      need_count <= 9'd0;
    end else if (cmd.emit) begin
      unique case (cmd.sel)
        SEL_SHIFT: shift_held <= map_q[NEED_BIT];
        SEL_MAKE: begin
          held_bits[kc] <= 1'b1;
          if (map_q[NEED_BIT]) begin
            need_count <= need_count + 9'd1;
          end
        end
        SEL_BREAK: begin
          held_bits[kc] <= 1'b0;
          need_count    <= count_after;
        end
        SEL_UNSHIFT: shift_held <= 1'b0;
        SEL_FLUSH: begin
          if (cmd.last) begin
            held_bits  <= '0;
            shift_held <= 1'b0;
            need_count <= 9'd0;
          end
        end
        default: ;
      endcase
    end
  end

  // Flush position counter
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      flush_cnt <= '0;
    end else if (cmd.emit && cmd.sel == SEL_FLUSH) begin
      flush_cnt <= flush_cnt + 1'b1;
    end
  end

  // Build the outgoing word
  always_comb begin
    word.result_kind = KIND_CODE;
    word.matrix_code = 8'd0;
    word.last        = cmd.last;
    unique case (cmd.sel)
      SEL_CHORD:   word.result_kind = KIND_RESET;
      SEL_SHIFT:   word.matrix_code = {!map_q[NEED_BIT], 1'b0, shift_position};
      SEL_MAKE:    word.matrix_code = {2'b00, map_q[POS_W-1:0]};
      SEL_BREAK:   word.matrix_code = {2'b10, held_q[POS_W-1:0]};
      SEL_UNSHIFT: word.matrix_code = {2'b10, shift_position};
      SEL_FLUSH:   word.matrix_code = {2'b10, flush_cnt};
      default: ;
    endcase
  end

  // Output register
  assign out_free = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res <= word;
    end
  end

  assign stat.flags      = flags;
  assign stat.out_free   = out_free;
  assign stat.flush_done = (flush_cnt == POS_W'(MATRIX_KEYS - 1));

  // Release-all leaves nothing held
  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.sel == SEL_FLUSH && cmd.last) |=>
      (held_bits == '0 && !shift_held && need_count == 9'd0))
    else $error("release-all left keys held");

  // Shift word sets the shift state to what the key needs
  a_shift_state: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.sel == SEL_SHIFT) |=> shift_held == $past(map_q[NEED_BIT]))
    else $error("shift state out of step with shift word");

  // A shifted make bumps the need count
  a_need_count: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.sel == SEL_MAKE && map_q[NEED_BIT]) |=>
      need_count == 9'($past(need_count) + 9'd1))
    else $error("need count not advanced on shifted make");

endmodule
`default_nettype wire
